@@ rtl/core/sstf_pkg.sv @@
// Shared types and constants for the shortest-seek-first scheduler.
// Used by sstf_cell, sstf_ctrl and shortest_seek_first_scheduler_unit.
// No dependencies.
package sstf_pkg;

  // Number of request slots in the cell row (valid range 2 to 63).
  localparam int MAX_REQUESTS = 32;
  localparam int IDX_W        = $clog2(MAX_REQUESTS);
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);

  // Field widths
  localparam int CYL_W   = 16;
  localparam int NUM_W   = 6;
  localparam int DIST_W  = 16;
  localparam int TOTAL_W = 21;
  localparam int SUM_W   = 22;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 64;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_LAUNCH,
    ST_SCAN
  } state_t;

  // Search token that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [DIST_W-1:0] seek;
    logic [IDX_W-1:0]  idx;
    logic [CYL_W-1:0]  cyl;
    logic [NUM_W-1:0]  num;
    logic [CYL_W-1:0]  first_cyl;
    logic [NUM_W-1:0]  first_num;
  } token_t;

  // Broadcast write of an arriving request into one cell.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [CYL_W-1:0] cyl;
    logic [NUM_W-1:0] num;
  } load_t;

  // Broadcast swap after a pick: the picked cell takes the first pending
  // entry, and the first pending cell is retired.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] best_idx;
    logic [IDX_W-1:0] first_idx;
    logic [CYL_W-1:0] first_cyl;
    logic [NUM_W-1:0] first_num;
  } upd_t;

endpackage

@@ rtl/core/sstf_cell.sv @@
// One request slot of the scheduler row, with its stage of the search token.
// Depends on sstf_pkg.
module sstf_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sstf_pkg::IDX_W-1:0]    cell_idx,
  input  logic [sstf_pkg::CYL_W-1:0]    head,
  input  logic [sstf_pkg::IDX_W-1:0]    first_idx,
  input  sstf_pkg::load_t               load,
  input  sstf_pkg::upd_t                upd,
  input  sstf_pkg::token_t              tok_in,
  output sstf_pkg::token_t              tok_out
);

  logic [sstf_pkg::CYL_W-1:0]  cyl_r;
  logic [sstf_pkg::NUM_W-1:0]  num_r;
  logic                        pending_r;
  logic [sstf_pkg::DIST_W-1:0] cell_seek;
  sstf_pkg::token_t            tok_r;
  sstf_pkg::token_t            tok_nxt;

  // Distance from the head to this slot's cylinder.
  assign cell_seek = (cyl_r >= head) ? (cyl_r - head) : (head - cyl_r);

  // Fold this slot into the passing token; strict compare keeps the lower slot on a tie.
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && pending_r) begin
      if (!tok_in.found || (cell_seek < tok_in.seek)) begin
        tok_nxt.found = 1'b1;
        tok_nxt.seek  = cell_seek;
        tok_nxt.idx   = cell_idx;
        tok_nxt.cyl   = cyl_r;
        tok_nxt.num   = num_r;
      end
      if (cell_idx == first_idx) begin
        tok_nxt.first_cyl = cyl_r;
        tok_nxt.first_num = num_r;
      end
    end
  end

  // Token stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

  // Slot contents: written on arrival, or overwritten by the swap after a pick.
  always_ff @(posedge clk) begin
    if (load.en && (load.idx == cell_idx)) begin
      cyl_r <= load.cyl;
      num_r <= load.num;
    end else if (upd.en && (upd.best_idx == cell_idx)) begin
      cyl_r <= upd.first_cyl;
      num_r <= upd.first_num;
    end
  end

  // Pending flag: set on arrival, cleared when the slot is the first pending one retired by the swap.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
    end else if (load.en && (load.idx == cell_idx)) begin
      pending_r <= 1'b1;
    end else if (upd.en && (upd.first_idx == cell_idx)) begin
      pending_r <= 1'b0;
    end
  end

endmodule

@@ rtl/core/sstf_ctrl.sv @@
// Sequencer of the scheduler: loading, token launch, pick, swap and result register.
// Depends on sstf_pkg.
module sstf_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel handshake and payload
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sstf_pkg::CYL_W-1:0]      in_cyl,
  input  logic                            in_last,
  // Start head register write
  input  logic                            cfg_valid,
  input  logic [sstf_pkg::CYL_W-1:0]      cfg_data,
  // Result register
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sstf_pkg::NUM_W-1:0]      out_num,
  output logic [sstf_pkg::CYL_W-1:0]      out_cyl,
  output logic [sstf_pkg::DIST_W-1:0]     out_dist,
  output logic [sstf_pkg::TOTAL_W-1:0]    out_total,
  output logic                            out_last,
  // Cell row
  output logic [sstf_pkg::CYL_W-1:0]      head,
  output logic [sstf_pkg::IDX_W-1:0]      first_idx,
  output sstf_pkg::load_t                 load,
  output sstf_pkg::upd_t                  upd,
  output sstf_pkg::token_t                tok_launch,
  input  sstf_pkg::token_t                tok_done
);

  localparam logic [sstf_pkg::CNT_W-1:0] MAX_CNT = sstf_pkg::CNT_W'(sstf_pkg::MAX_REQUESTS);

  sstf_pkg::state_t               state_r, state_nxt;
  logic [sstf_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [sstf_pkg::CNT_W-1:0]     first_r, first_nxt;
  logic [sstf_pkg::CNT_W:0]       count_inc;
  logic [sstf_pkg::CNT_W:0]       first_inc;
  logic [sstf_pkg::CYL_W-1:0]     start_head_r;
  logic [sstf_pkg::CYL_W-1:0]     head_r, head_nxt;
  logic [sstf_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic [sstf_pkg::SUM_W-1:0]     sum_add;
  logic                           out_valid_r, out_valid_nxt;
  logic [sstf_pkg::NUM_W-1:0]     out_num_r;
  logic [sstf_pkg::CYL_W-1:0]     out_cyl_r;
  logic [sstf_pkg::DIST_W-1:0]    out_dist_r;
  logic [sstf_pkg::TOTAL_W-1:0]   out_total_r;
  logic                           out_last_r;
  logic                           in_fire;
  logic                           out_free;
  logic                           pick;
  logic                           batch_end;

  assign in_tready = (state_r == sstf_pkg::ST_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_ready;
  assign pick      = (state_r == sstf_pkg::ST_SCAN) && tok_done.valid;
  assign count_inc = {1'b0, count_r} + 1'b1;
  assign first_inc = {1'b0, first_r} + 1'b1;
  assign batch_end = (first_inc == {1'b0, count_r});
  assign sum_add   = sum_r + sstf_pkg::SUM_W'(tok_done.seek);

  // Start head register; always ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_head_r <= '0;
    end else if (cfg_valid) begin
      start_head_r <= cfg_data;
    end
  end

  // Arriving request goes to the next free slot; a request past capacity is dropped.
  always_comb begin
    load.en  = in_fire && (count_r < MAX_CNT);
    load.idx = count_r[sstf_pkg::IDX_W-1:0];
    load.cyl = in_cyl;
    load.num = sstf_pkg::NUM_W'(count_inc);
  end

  // Swap broadcast on each pick.
  always_comb begin
    upd.en        = pick;
    upd.best_idx  = tok_done.idx;
    upd.first_idx = first_r[sstf_pkg::IDX_W-1:0];
    upd.first_cyl = tok_done.first_cyl;
    upd.first_num = tok_done.first_num;
  end

  // Fresh token enters slot zero once the result register can take its pick.
  always_comb begin
    tok_launch       = '0;
    tok_launch.valid = (state_r == sstf_pkg::ST_LAUNCH) && out_free;
  end

  // Next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    first_nxt     = first_r;
    head_nxt      = head_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      sstf_pkg::ST_LOAD: begin
        if (load.en) begin
          count_nxt = count_inc[sstf_pkg::CNT_W-1:0];
        end
        if (in_fire && in_last) begin
          head_nxt  = start_head_r;
          sum_nxt   = '0;
          first_nxt = '0;
          state_nxt = sstf_pkg::ST_LAUNCH;
        end
      end
      sstf_pkg::ST_LAUNCH: begin
        if (out_free) begin
          state_nxt = sstf_pkg::ST_SCAN;
        end
      end
      sstf_pkg::ST_SCAN: begin
        if (pick) begin
          out_valid_nxt = 1'b1;
          sum_nxt       = sum_add;
          head_nxt      = tok_done.cyl;
          if (batch_end) begin
            count_nxt = '0;
            first_nxt = '0;
            state_nxt = sstf_pkg::ST_LOAD;
          end else begin
            first_nxt = first_inc[sstf_pkg::CNT_W-1:0];
            state_nxt = sstf_pkg::ST_LAUNCH;
          end
        end
      end
      default: begin
        state_nxt = sstf_pkg::ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sstf_pkg::ST_LOAD;
      count_r     <= '0;
      first_r     <= '0;
      head_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      first_r     <= first_nxt;
      head_r      <= head_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded on each pick.
  always_ff @(posedge clk) begin
    if (pick) begin
      out_num_r   <= tok_done.num;
      out_cyl_r   <= tok_done.cyl;
      out_dist_r  <= tok_done.seek;
      out_total_r <= sum_add[sstf_pkg::TOTAL_W-1:0];
      out_last_r  <= batch_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_num   = out_num_r;
  assign out_cyl   = out_cyl_r;
  assign out_dist  = out_dist_r;
  assign out_total = out_total_r;
  assign out_last  = out_last_r;
  assign head      = head_r;
  assign first_idx = first_r[sstf_pkg::IDX_W-1:0];

  // A token only leaves the row while the sequencer waits for it.
  a_token_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    tok_done.valid |-> (state_r == sstf_pkg::ST_SCAN))
    else $error("search token arrived outside a scan");

  // Every scan runs over a nonempty pending set, so it must find a slot.
  a_token_found : assert property (@(posedge clk) disable iff (!rst_n)
    tok_done.valid |-> tok_done.found)
    else $error("search token finished without a pending slot");

  // While serving, the served count stays below the loaded count.
  a_first_below_count : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != sstf_pkg::ST_LOAD) |-> (first_r < count_r))
    else $error("served count reached the loaded count while serving");

  // The loaded count never exceeds the number of slots.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("loaded count beyond capacity");

  // A pick never finds the result register still holding an untaken result.
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    pick |-> !out_valid_r)
    else $error("pick would overwrite a pending result");

endmodule

@@ rtl/core/shortest_seek_first_scheduler_unit.sv @@
// Shortest-seek-first disk request scheduler: top level with the cell row and sequencer.
// Depends on sstf_pkg, sstf_cell and sstf_ctrl.
//
// Requests are taken one per cycle into a row of MAX_REQUESTS slot cells and numbered
// from 1 in arrival order; a request beyond capacity is dropped, but its tlast still
// starts service. On tlast the input stalls and the batch is served from the head
// position last written on the cfg port. For each pick a search token is launched into slot
// zero and moves one cell per clock down the row, through the token stage register of
// every cell, so the time per result is set by the length of the cell row. The next
// token is launched only once the result register is free, so a slow consumer
// stretches the pick interval. The input opens again as soon as the last pick of a
// batch is made.
module shortest_seek_first_scheduler_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // Requests
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sstf_pkg::IN_DATA_W-1:0]     in_tdata,   // [15:0] cylinder
  input  logic                               in_tlast,   // end_of_batch
  // Start head register
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sstf_pkg::CYL_W-1:0]         cfg_data,   // [15:0] start_head
  // Served requests
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [5:0] request_number, [21:6] served_cylinder, [37:22] seek_distance,
  // [58:38] total_seek, [63:59] zero
  output logic [sstf_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast   // last_served
);

  localparam int PAD_W = sstf_pkg::OUT_DATA_W - sstf_pkg::NUM_W - sstf_pkg::CYL_W
                       - sstf_pkg::DIST_W - sstf_pkg::TOTAL_W;

  logic [sstf_pkg::CYL_W-1:0]    head;
  logic [sstf_pkg::IDX_W-1:0]    first_idx;
  sstf_pkg::load_t               load;
  sstf_pkg::upd_t                upd;
  sstf_pkg::token_t              tok [sstf_pkg::MAX_REQUESTS+1];
  logic [sstf_pkg::NUM_W-1:0]    out_num;
  logic [sstf_pkg::CYL_W-1:0]    out_cyl;
  logic [sstf_pkg::DIST_W-1:0]   out_dist;
  logic [sstf_pkg::TOTAL_W-1:0]  out_total;

  assign cfg_ready = 1'b1;

  // Sequencer and result register.
  sstf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cyl     (in_tdata[sstf_pkg::CYL_W-1:0]),
    .in_last    (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_num    (out_num),
    .out_cyl    (out_cyl),
    .out_dist   (out_dist),
    .out_total  (out_total),
    .out_last   (out_tlast),
    .head       (head),
    .first_idx  (first_idx),
    .load       (load),
    .upd        (upd),
    .tok_launch (tok[0]),
    .tok_done   (tok[sstf_pkg::MAX_REQUESTS])
  );

  // Row of slot cells; the search token passes from each cell to the next.
  for (genvar i = 0; i < sstf_pkg::MAX_REQUESTS; i++) begin : g_cell
    sstf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (sstf_pkg::IDX_W'(i)),
      .head      (head),
      .first_idx (first_idx),
      .load      (load),
      .upd       (upd),
      .tok_in    (tok[i]),
      .tok_out   (tok[i+1])
    );
  end

  assign out_tdata = {{PAD_W{1'b0}}, out_total, out_dist, out_cyl, out_num};

endmodule
